FILE: hdl/ttx28_pkg.sv
// Shared types, constants and tables for the X/28 packet decoder and colour lookup.
`timescale 1ns / 1ps
package ttx28_pkg;

   localparam int TRIPLET_COUNT       = 13;
   localparam int CHAR_BITS           = 6;
   localparam int PKT_LEN             = 1 + 3 * TRIPLET_COUNT;
   localparam int SLOT_COUNT          = 3 * TRIPLET_COUNT - 1;
   localparam int PACKET_BITS         = 3 * TRIPLET_COUNT * CHAR_BITS;
   localparam int POS_W               = $clog2(PKT_LEN);
   localparam int PALETTE_DEPTH       = 16;
   localparam int PALETTE_BASE        = 28;
   localparam int LAST_TRIPLET_BASE   = 18 * (TRIPLET_COUNT - 1);
   localparam int QUEUE_DEPTH_DEFAULT = 2;

   typedef logic [1:0] kind_type;
   localparam kind_type KIND_LOOKUP = 2'd0;
   localparam kind_type KIND_DESIG  = 2'd1;
   localparam kind_type KIND_SLOT   = 2'd2;
   localparam kind_type KIND_LAST   = 2'd3;

   typedef struct packed {
      kind_type               kind;
      logic [POS_W-1:0]       slot;
      logic [CHAR_BITS-1:0]   char_bits;
      logic [2:0]             colour_code;
      logic                   use_foreground;
   } entry_type;

   typedef struct packed {
      logic        packet_done;
      logic [11:0] rgb;
      logic [5:0]  designation;
      logic [3:0]  page_function;
      logic [2:0]  page_coding;
      logic [6:0]  primary_charset;
      logic [6:0]  second_charset;
      logic        left_panel_on;
      logic        right_panel_on;
      logic        panel_status;
      logic [3:0]  left_column_count;
      logic [4:0]  screen_colour;
   } result_type;

   localparam logic [11:0] FIXED_CLUT [0:1][0:7] = '{
      '{12'h000, 12'hf00, 12'h0f0, 12'hff0, 12'h00f, 12'hf0f, 12'h0ff, 12'hfff},
      '{12'h000, 12'h700, 12'h070, 12'h770, 12'h007, 12'h707, 12'h077, 12'h777}
   };

   localparam logic [11:0] PALETTE_DEFAULT [0:PALETTE_DEPTH-1] = '{
      12'hf05, 12'hf70, 12'h0f7, 12'hffb, 12'h0ca, 12'h500, 12'h652, 12'hc77,
      12'h333, 12'hf77, 12'h7f7, 12'hff7, 12'h77f, 12'hf7f, 12'h7ff, 12'hddd
   };

endpackage

FILE: hdl/ttx28_if.sv
// Request and response channel interfaces of the X/28 decoder.
`timescale 1ns / 1ps
interface ttx28_req_if;
   logic       valid;
   logic       ready;
   logic       mode;
   logic [7:0] packet_char;
   logic [2:0] colour_code;
   logic       use_foreground;

   modport source (output valid, mode, packet_char, colour_code, use_foreground,
                   input ready);
   modport sink (input valid, mode, packet_char, colour_code, use_foreground,
                 output ready);
endinterface

interface ttx28_rsp_if;
   logic        valid;
   logic        ready;
   logic        packet_done;
   logic [11:0] rgb;
   logic [5:0]  designation;
   logic [3:0]  page_function;
   logic [2:0]  page_coding;
   logic [6:0]  primary_charset;
   logic [6:0]  second_charset;
   logic        left_panel_on;
   logic        right_panel_on;
   logic        panel_status;
   logic [3:0]  left_column_count;
   logic [4:0]  screen_colour;

   modport source (output valid, packet_done, rgb, designation, page_function,
                   page_coding, primary_charset, second_charset, left_panel_on,
                   right_panel_on, panel_status, left_column_count, screen_colour,
                   input ready);
   modport sink (input valid, packet_done, rgb, designation, page_function,
                 page_coding, primary_charset, second_charset, left_panel_on,
                 right_panel_on, panel_status, left_column_count, screen_colour,
                 output ready);
endinterface

FILE: hdl/ttx28_front.sv
// Front end: accepts requests, tracks packet position and classifies each request.
`timescale 1ns / 1ps
module ttx28_front (
   input  logic                  clock,
   input  logic                  reset,
   ttx28_req_if.sink             req_ch,
   input  logic                  queue_full,
   output logic                  push,
   output ttx28_pkg::entry_type  push_data
);
   import ttx28_pkg::*;

   logic [POS_W-1:0] pos_ff;
   logic [POS_W-1:0] pos_in;
   logic             is_last;

   assign req_ch.ready = !queue_full;
   assign push         = req_ch.valid && !queue_full;
   assign is_last      = (pos_ff == POS_W'(PKT_LEN - 1));

   always_comb begin
      push_data.slot           = pos_ff - POS_W'(1);
      push_data.char_bits      = req_ch.packet_char[CHAR_BITS-1:0];
      push_data.colour_code    = req_ch.colour_code;
      push_data.use_foreground = req_ch.use_foreground;
      priority if (req_ch.mode) begin
         push_data.kind = KIND_LOOKUP;
      end else if (pos_ff == '0) begin
         push_data.kind = KIND_DESIG;
      end else if (is_last) begin
         push_data.kind = KIND_LAST;
      end else begin
         push_data.kind = KIND_SLOT;
      end
   end

   always_comb begin
      pos_in = pos_ff;
      if (push && !req_ch.mode) begin
         pos_in = is_last ? '0 : pos_ff + POS_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else begin
         pos_ff <= pos_in;
      end
   end

`ifndef ASSERT_OFF
   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      pos_ff < POS_W'(PKT_LEN))
      else $error("packet position beyond packet length");
`endif

endmodule

FILE: hdl/ttx28_queue.sv
// Short request queue between the front end and the back end.
`timescale 1ns / 1ps
module ttx28_queue #(
   parameter int DEPTH = ttx28_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  ttx28_pkg::entry_type  push_data,
   input  logic                  pop,
   output logic                  full,
   output logic                  head_valid,
   output ttx28_pkg::entry_type  head_data
);
   import ttx28_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   entry_type        mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_data  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue count beyond depth");
`endif

endmodule

FILE: hdl/ttx28_back.sv
// Back end: assembles packet characters, updates the palette and answers lookups.
`timescale 1ns / 1ps
module ttx28_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  head_valid,
   input  ttx28_pkg::entry_type  head_data,
   output logic                  pop,
   ttx28_rsp_if.source           rsp_ch
);
   import ttx28_pkg::*;

   logic [CHAR_BITS-1:0] slot_ff [SLOT_COUNT];
   logic [11:0]          palette_ff [PALETTE_DEPTH];
   logic [11:0]          palette_in [PALETTE_DEPTH];
   logic [4:0]           row_colour_ff;
   logic                 black_sub_ff;
   logic [2:0]           remap_ff;
   logic [5:0]           desig_ff;
   logic                 out_valid_ff, out_valid_in;
   result_type           out_data_ff, out_data_in;

   logic [PACKET_BITS-1:0] flat;
   logic [17:0]            last_trip;
   logic                   produces;
   logic [1:0]             lk_clut;
   logic [2:0]             lk_entry;
   logic [11:0]            lk_rgb;

   assign produces = (head_data.kind == KIND_LOOKUP) || (head_data.kind == KIND_LAST);
   assign pop      = head_valid && (!produces || !out_valid_ff || rsp_ch.ready);

   always_comb begin
      for (int k = 0; k < SLOT_COUNT; k++) begin
         flat[k*CHAR_BITS +: CHAR_BITS] = slot_ff[k];
      end
      flat[SLOT_COUNT*CHAR_BITS +: CHAR_BITS] = head_data.char_bits;
   end

   assign last_trip = flat[LAST_TRIPLET_BASE +: 18];

   always_comb begin
      for (int n = 0; n < PALETTE_DEPTH; n++) begin
         palette_in[n] = {flat[PALETTE_BASE + 12*n +: 4],
                          flat[PALETTE_BASE + 12*n + 4 +: 4],
                          flat[PALETTE_BASE + 12*n + 8 +: 4]};
      end
   end

   always_comb begin
      lk_entry = head_data.colour_code;
      if (black_sub_ff && !head_data.use_foreground && head_data.colour_code == 3'd0) begin
         lk_clut  = row_colour_ff[4:3];
         lk_entry = row_colour_ff[2:0];
      end else if (head_data.use_foreground) begin
         unique case (remap_ff)
            3'd0, 3'd1, 3'd2: lk_clut = 2'd0;
            3'd3, 3'd4:       lk_clut = 2'd1;
            default:          lk_clut = 2'd2;
         endcase
      end else begin
         unique case (remap_ff)
            3'd0, 3'd1, 3'd2: lk_clut = remap_ff[1:0];
            3'd3, 3'd5:       lk_clut = 2'd1;
            3'd4, 3'd6:       lk_clut = 2'd2;
            default:          lk_clut = 2'd3;
         endcase
      end
      lk_rgb = lk_clut[1] ? palette_ff[{lk_clut[0], lk_entry}]
                          : FIXED_CLUT[lk_clut[0]][lk_entry];
   end

   always_comb begin
      out_data_in = '0;
      if (head_data.kind == KIND_LAST) begin
         out_data_in.packet_done       = 1'b1;
         out_data_in.designation       = desig_ff;
         out_data_in.page_function     = flat[3:0];
         out_data_in.page_coding       = flat[6:4];
         out_data_in.primary_charset   = flat[13:7];
         out_data_in.second_charset    = flat[20:14];
         out_data_in.left_panel_on     = flat[21];
         out_data_in.right_panel_on    = flat[22];
         out_data_in.panel_status      = flat[23];
         out_data_in.left_column_count = flat[27:24];
         out_data_in.screen_colour     = last_trip[8:4];
      end else begin
         out_data_in.rgb = lk_rgb;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff && !rsp_ch.ready;
      if (pop && produces) begin
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < SLOT_COUNT; k++) begin
         if (pop && head_data.kind == KIND_SLOT && head_data.slot == POS_W'(k)) begin
            slot_ff[k] <= head_data.char_bits;
         end
      end
      if (pop && produces) begin
         out_data_ff <= out_data_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int n = 0; n < PALETTE_DEPTH; n++) begin
            palette_ff[n] <= PALETTE_DEFAULT[n];
         end
         row_colour_ff <= '0;
         black_sub_ff  <= 1'b0;
         remap_ff      <= '0;
         desig_ff      <= '0;
         out_valid_ff  <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (pop && head_data.kind == KIND_DESIG) begin
            desig_ff <= head_data.char_bits;
         end
         if (pop && head_data.kind == KIND_LAST) begin
            for (int n = 0; n < PALETTE_DEPTH; n++) begin
               palette_ff[n] <= palette_in[n];
            end
            row_colour_ff <= last_trip[13:9];
            black_sub_ff  <= last_trip[14];
            remap_ff      <= last_trip[17:15];
         end
      end
   end

   assign rsp_ch.valid             = out_valid_ff;
   assign rsp_ch.packet_done       = out_data_ff.packet_done;
   assign rsp_ch.rgb               = out_data_ff.rgb;
   assign rsp_ch.designation       = out_data_ff.designation;
   assign rsp_ch.page_function     = out_data_ff.page_function;
   assign rsp_ch.page_coding       = out_data_ff.page_coding;
   assign rsp_ch.primary_charset   = out_data_ff.primary_charset;
   assign rsp_ch.second_charset    = out_data_ff.second_charset;
   assign rsp_ch.left_panel_on     = out_data_ff.left_panel_on;
   assign rsp_ch.right_panel_on    = out_data_ff.right_panel_on;
   assign rsp_ch.panel_status      = out_data_ff.panel_status;
   assign rsp_ch.left_column_count = out_data_ff.left_column_count;
   assign rsp_ch.screen_colour     = out_data_ff.screen_colour;

`ifndef ASSERT_OFF
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      pop && produces |=> out_valid_ff)
      else $error("result-producing request did not load the output register");
   a_slot_range: assert property (@(posedge clock) disable iff (reset)
      pop && head_data.kind == KIND_SLOT |-> head_data.slot < POS_W'(SLOT_COUNT))
      else $error("character slot index out of range");
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_ch.ready |-> !(pop && produces))
      else $error("pending response overwritten");
`endif

endmodule

FILE: hdl/teletext_x28_clut_decode_remap.sv
// Top level of the X/28 packet decoder with colour lookup.
// A request that yields a response passes the request queue between front and back
// end, then the back end's output register. Throughput: one request per cycle,
// packet characters and lookups alike, while the response channel takes results.
// Reset: packet position, palette (to default CLUT 2 and 3), row colour, flags and
// remap mode are restored in the reset cycle; no clearing pass follows.
`timescale 1ns / 1ps
module teletext_x28_clut_decode_remap #(
   parameter int QUEUE_DEPTH = ttx28_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   ttx28_req_if.sink    req_ch,
   ttx28_rsp_if.source  rsp_ch
);
   import ttx28_pkg::*;

   logic      push;
   logic      pop;
   logic      queue_full;
   logic      head_valid;
   entry_type push_data;
   entry_type head_data;

   ttx28_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .queue_full (queue_full),
      .push       (push),
      .push_data  (push_data)
   );

   ttx28_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  (push_data),
      .pop        (pop),
      .full       (queue_full),
      .head_valid (head_valid),
      .head_data  (head_data)
   );

   ttx28_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_data  (head_data),
      .pop        (pop),
      .rsp_ch     (rsp_ch)
   );

endmodule
